@@ rtl/cpcg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_pkg
// Shared widths, codes and controller/datapath link types for the collision
// pair candidate generator.
// ----------------------------------------------------------------------------
package cpcg_pkg;

    // fixed field widths of the request and response beats
    localparam int FUNC_W      = 3;
    localparam int GROUP_ID_W  = 16;
    localparam int VERT_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 10;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_KIND_MASK   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_CHECK = 1'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR      = 3'd0,
        FUNC_ADD_VERTEX = 3'd1,
        FUNC_ADD_EDGE   = 3'd2,
        FUNC_ADD_FACE   = 3'd3,
        FUNC_NEXT       = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_FINISHED = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch the request beat
        logic exec;       // perform clear / add
        logic scan_step;  // one cursor step of the enumeration
        logic grp_start;  // reset the group read counter
        logic grp_step;   // one group table read / capture
        logic set_pair;   // current candidate is a result
        logic emit;       // move pending result to the output register
    } cpcg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic scan_cand;
        logic vtx_reject;
        logic grp_check;
        logic grp_last;
        logic grp_match;
        logic out_free;
    } cpcg_sts_t;

endpackage

@@ rtl/cpcg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_if
// Valid/ready channel interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface cpcg_req_if import cpcg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [GROUP_ID_W-1:0] group_id;
    logic [VERT_W-1:0]     vert_a;
    logic [VERT_W-1:0]     vert_b;
    logic [VERT_W-1:0]     vert_c;

    modport source (
        output valid, func, group_id, vert_a, vert_b, vert_c,
        input  ready
    );
    modport sink (
        input  valid, func, group_id, vert_a, vert_b, vert_c,
        output ready
    );
endinterface

interface cpcg_rsp_if import cpcg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   pair_kind;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  second_index;

    modport source (
        output valid, status, pair_kind, first_index, second_index,
        input  ready
    );
    modport sink (
        input  valid, status, pair_kind, first_index, second_index,
        output ready
    );
endinterface

@@ rtl/cpcg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/cpcg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_ctrl
// Sequencer: accepts a request, runs table updates or the pair scan, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module cpcg_ctrl import cpcg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] req_func,
    output logic              req_ready,
    input  cpcg_sts_t         sts,
    output cpcg_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_TCHK,
        S_GREAD,
        S_GCMP,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_func == FUNC_NEXT) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.scan_cand)
                begin
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                // table entry is on the ram output now
                if (sts.vtx_reject)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.grp_check)
                begin
                    cmd.grp_start = 1'b1;
                    state_next    = S_GREAD;
                end
                else
                begin
                    cmd.set_pair = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_GREAD:
            begin
                cmd.grp_step = 1'b1;
                if (sts.grp_last)
                begin
                    state_next = S_GCMP;
                end
            end
            S_GCMP:
            begin
                if (sts.grp_match)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.set_pair = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/cpcg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_dp
// Datapath: vertex group, edge and face tables, counts, scan cursors,
// candidate rejection and the result registers.
// ----------------------------------------------------------------------------
module cpcg_dp import cpcg_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 1024,
    parameter int MAX_FACES    = 1024,
    parameter int GROUP_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [FUNC_W-1:0]      func,
    input  logic [GROUP_ID_W-1:0]  group_id,
    input  logic [VERT_W-1:0]      vert_a,
    input  logic [VERT_W-1:0]      vert_b,
    input  logic [VERT_W-1:0]      vert_c,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cpcg_cmd_t              cmd,
    output cpcg_sts_t              sts,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_W-1:0]    rsp_status,
    output logic [KIND_W-1:0]      rsp_pair_kind,
    output logic [INDEX_W-1:0]     rsp_first_index,
    output logic [INDEX_W-1:0]     rsp_second_index
);

    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int FCW  = $clog2(MAX_FACES + 1);
    localparam int VIW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FIW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int MCW  = (VCW > ECW) ? ((VCW > FCW) ? VCW : FCW)
                                      : ((ECW > FCW) ? ECW : FCW);
    localparam int CUW  = MCW + 1;
    localparam int CMPW = (CUW > VERT_W) ? CUW : VERT_W;
    localparam int EW   = 2 * VERT_W;
    localparam int FW   = 3 * VERT_W;

    typedef enum logic [1:0] {
        PH_EV   = 2'd0,
        PH_EE   = 2'd1,
        PH_FV   = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // control state
    logic [VCW-1:0] vcnt_reg;
    logic [ECW-1:0] ecnt_reg;
    logic [FCW-1:0] fcnt_reg;
    phase_t         phase_reg;
    logic [CUW-1:0] outer_reg;
    logic [CUW-1:0] inner_reg;
    logic [2:0]     kind_mask_reg;
    logic           grp_chk_reg;
    logic [2:0]     rd_idx_reg;
    logic           out_valid_reg;

    // payload
    logic [FUNC_W-1:0]     func_reg;
    logic [GROUP_ID_W-1:0] gid_reg;
    logic [VERT_W-1:0]     va_reg;
    logic [VERT_W-1:0]     vb_reg;
    logic [VERT_W-1:0]     vc_reg;
    logic [CUW-1:0]        cand_o_reg;
    logic [CUW-1:0]        cand_i_reg;
    logic [GROUP_BITS-1:0] grp_reg [4];
    logic [STATUS_W-1:0]   pend_status_reg;
    logic [KIND_W-1:0]     pend_kind_reg;
    logic [INDEX_W-1:0]    pend_first_reg;
    logic [INDEX_W-1:0]    pend_second_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [INDEX_W-1:0]    out_first_reg;
    logic [INDEX_W-1:0]    out_second_reg;

    // ------------------------------------------------------------------
    // table updates
    // ------------------------------------------------------------------
    logic v_full;
    logic e_full;
    logic f_full;
    logic va_bad;
    logic vb_bad;
    logic vc_bad;
    logic add_v_ok;
    logic add_e_ok;
    logic add_f_ok;
    logic is_add;
    logic is_clear;

    assign v_full   = vcnt_reg >= VCW'(MAX_VERTICES);
    assign e_full   = ecnt_reg >= ECW'(MAX_EDGES);
    assign f_full   = fcnt_reg >= FCW'(MAX_FACES);
    assign va_bad   = CMPW'(va_reg) >= CMPW'(vcnt_reg);
    assign vb_bad   = CMPW'(vb_reg) >= CMPW'(vcnt_reg);
    assign vc_bad   = CMPW'(vc_reg) >= CMPW'(vcnt_reg);
    assign add_v_ok = (func_reg == FUNC_ADD_VERTEX) && !v_full;
    assign add_e_ok = (func_reg == FUNC_ADD_EDGE) && !e_full && !va_bad && !vb_bad;
    assign add_f_ok = (func_reg == FUNC_ADD_FACE) && !f_full && !va_bad && !vb_bad
                      && !vc_bad;
    assign is_add   = (func_reg == FUNC_ADD_VERTEX) || (func_reg == FUNC_ADD_EDGE)
                      || (func_reg == FUNC_ADD_FACE);
    assign is_clear = (func_reg == FUNC_CLEAR);

    // ------------------------------------------------------------------
    // scan step
    // ------------------------------------------------------------------
    logic           kind_en;
    logic [CUW-1:0] lim_o;
    logic [CUW-1:0] lim_i;
    logic [CUW-1:0] inner_eff;
    logic [CUW-1:0] outer_p1;
    logic [CUW-1:0] outer_p2;
    logic [CUW-1:0] inner_p1;
    logic           scan_done;
    logic           adv_phase;
    logic           adv_outer;
    logic           scan_cand;
    phase_t         phase_succ;

    assign outer_p1 = CUW'(outer_reg + 1'b1);
    assign outer_p2 = CUW'(outer_reg + 2'd2);
    assign inner_p1 = CUW'(inner_eff + 1'b1);

    always_comb
    begin
        kind_en    = 1'b0;
        lim_o      = '0;
        lim_i      = '0;
        inner_eff  = inner_reg;
        phase_succ = PH_DONE;
        case (phase_reg)
            PH_EV:
            begin
                kind_en    = kind_mask_reg[0];
                lim_o      = CUW'(ecnt_reg);
                lim_i      = CUW'(vcnt_reg);
                phase_succ = PH_EE;
            end
            PH_EE:
            begin
                kind_en    = kind_mask_reg[1];
                lim_o      = CUW'(ecnt_reg);
                lim_i      = CUW'(ecnt_reg);
                // the inner edge index is always above the outer one
                inner_eff  = (inner_reg <= outer_reg) ? outer_p1 : inner_reg;
                phase_succ = PH_FV;
            end
            PH_FV:
            begin
                kind_en    = kind_mask_reg[2];
                lim_o      = CUW'(fcnt_reg);
                lim_i      = CUW'(vcnt_reg);
                phase_succ = PH_DONE;
            end
            default:
            begin
                kind_en    = 1'b0;
            end
        endcase
    end

    assign scan_done = (phase_reg == PH_DONE);
    assign adv_phase = !scan_done && (!kind_en || (outer_reg >= lim_o));
    assign adv_outer = !scan_done && !adv_phase && (inner_eff >= lim_i);
    assign scan_cand = !scan_done && !adv_phase && !adv_outer;

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    logic                  tbl_re;
    logic [GROUP_BITS-1:0] grp_rdata;
    logic [EW-1:0]         edge_a_rdata;
    logic [EW-1:0]         edge_b_rdata;
    logic [FW-1:0]         face_rdata;
    logic                  grp_re;
    logic [VIW-1:0]        grp_raddr;

    assign tbl_re = cmd.scan_step && scan_cand;

    cpcg_ram #(
        .WIDTH (GROUP_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_grp_ram (
        .clk   (clk),
        .we    (cmd.exec && add_v_ok),
        .waddr (vcnt_reg[VIW-1:0]),
        .wdata (GROUP_BITS'(gid_reg)),
        .re    (grp_re),
        .raddr (grp_raddr),
        .rdata (grp_rdata)
    );

    // two copies of the edge table so both edges of a pair read at once
    cpcg_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram_a (
        .clk   (clk),
        .we    (cmd.exec && add_e_ok),
        .waddr (ecnt_reg[EIW-1:0]),
        .wdata ({va_reg, vb_reg}),
        .re    (tbl_re),
        .raddr (outer_reg[EIW-1:0]),
        .rdata (edge_a_rdata)
    );

    cpcg_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram_b (
        .clk   (clk),
        .we    (cmd.exec && add_e_ok),
        .waddr (ecnt_reg[EIW-1:0]),
        .wdata ({va_reg, vb_reg}),
        .re    (tbl_re),
        .raddr (inner_eff[EIW-1:0]),
        .rdata (edge_b_rdata)
    );

    cpcg_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_FACES)
    ) u_face_ram (
        .clk   (clk),
        .we    (cmd.exec && add_f_ok),
        .waddr (fcnt_reg[FIW-1:0]),
        .wdata ({va_reg, vb_reg, vc_reg}),
        .re    (tbl_re),
        .raddr (outer_reg[FIW-1:0]),
        .rdata (face_rdata)
    );

    // ------------------------------------------------------------------
    // candidate checks
    // ------------------------------------------------------------------
    logic [VERT_W-1:0] ea;
    logic [VERT_W-1:0] eb;
    logic [VERT_W-1:0] ec;
    logic [VERT_W-1:0] ed;
    logic [VERT_W-1:0] fa;
    logic [VERT_W-1:0] fb;
    logic [VERT_W-1:0] fc;
    logic [CMPW-1:0]   v_x;
    logic              vtx_reject;
    logic [VIW-1:0]    gaddr [4];
    logic [2:0]        grp_need;
    logic              grp_match;
    logic [1:0]        cap_idx;

    assign ea  = edge_a_rdata[EW-1:VERT_W];
    assign eb  = edge_a_rdata[VERT_W-1:0];
    assign ec  = edge_b_rdata[EW-1:VERT_W];
    assign ed  = edge_b_rdata[VERT_W-1:0];
    assign fa  = face_rdata[FW-1:EW];
    assign fb  = face_rdata[EW-1:VERT_W];
    assign fc  = face_rdata[VERT_W-1:0];
    assign v_x = CMPW'(cand_i_reg);

    always_comb
    begin
        vtx_reject = 1'b0;
        grp_need   = 3'd4;
        grp_match  = 1'b0;
        gaddr[0]   = VIW'(cand_i_reg);
        gaddr[1]   = VIW'(fa);
        gaddr[2]   = VIW'(fb);
        gaddr[3]   = VIW'(fc);
        case (phase_reg)
            PH_EV:
            begin
                vtx_reject = (v_x == CMPW'(ea)) || (v_x == CMPW'(eb));
                grp_need   = 3'd3;
                gaddr[1]   = VIW'(ea);
                gaddr[2]   = VIW'(eb);
                grp_match  = (grp_reg[0] == grp_reg[1]) || (grp_reg[0] == grp_reg[2]);
            end
            PH_EE:
            begin
                vtx_reject = (ea == ec) || (ea == ed) || (eb == ec) || (eb == ed);
                gaddr[0]   = VIW'(ea);
                gaddr[1]   = VIW'(eb);
                gaddr[2]   = VIW'(ec);
                gaddr[3]   = VIW'(ed);
                grp_match  = (grp_reg[0] == grp_reg[2]) || (grp_reg[0] == grp_reg[3])
                             || (grp_reg[1] == grp_reg[2]) || (grp_reg[1] == grp_reg[3]);
            end
            PH_FV:
            begin
                vtx_reject = (v_x == CMPW'(fa)) || (v_x == CMPW'(fb))
                             || (v_x == CMPW'(fc));
                grp_match  = (grp_reg[0] == grp_reg[1]) || (grp_reg[0] == grp_reg[2])
                             || (grp_reg[0] == grp_reg[3]);
            end
            default:
            begin
                vtx_reject = 1'b0;
            end
        endcase
    end

    // group reads are pipelined: issue one, capture the previous one
    assign grp_re    = cmd.grp_step && (rd_idx_reg < grp_need);
    assign grp_raddr = gaddr[rd_idx_reg[1:0]];
    assign cap_idx   = 2'(rd_idx_reg - 3'd1);

    assign sts.scan_done  = scan_done;
    assign sts.scan_cand  = scan_cand;
    assign sts.vtx_reject = vtx_reject;
    assign sts.grp_check  = grp_chk_reg;
    assign sts.grp_last   = (rd_idx_reg == grp_need);
    assign sts.grp_match  = grp_match;
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            ecnt_reg      <= '0;
            fcnt_reg      <= '0;
            phase_reg     <= PH_EV;
            outer_reg     <= '0;
            inner_reg     <= '0;
            kind_mask_reg <= 3'b111;
            grp_chk_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KIND_MASK:   kind_mask_reg <= cfg_data;
                    CFG_GROUP_CHECK: grp_chk_reg   <= cfg_data[0];
                    default:         grp_chk_reg   <= grp_chk_reg;
                endcase
            end

            if (cmd.exec)
            begin
                if (is_clear)
                begin
                    vcnt_reg <= '0;
                    ecnt_reg <= '0;
                    fcnt_reg <= '0;
                end
                if (add_v_ok)
                begin
                    vcnt_reg <= VCW'(vcnt_reg + 1'b1);
                end
                if (add_e_ok)
                begin
                    ecnt_reg <= ECW'(ecnt_reg + 1'b1);
                end
                if (add_f_ok)
                begin
                    fcnt_reg <= FCW'(fcnt_reg + 1'b1);
                end
                // any clear or add, taken or not, restarts the scan
                if (is_clear || is_add)
                begin
                    phase_reg <= PH_EV;
                    outer_reg <= '0;
                    inner_reg <= '0;
                end
            end

            if (cmd.scan_step)
            begin
                if (adv_phase)
                begin
                    phase_reg <= phase_succ;
                    outer_reg <= '0;
                    inner_reg <= (phase_reg == PH_EV) ? CUW'(1) : '0;
                end
                else if (adv_outer)
                begin
                    outer_reg <= outer_p1;
                    inner_reg <= (phase_reg == PH_EE) ? outer_p2 : '0;
                end
                else if (scan_cand)
                begin
                    inner_reg <= inner_p1;
                end
            end

            if (cmd.grp_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.grp_step)
            begin
                rd_idx_reg <= 3'(rd_idx_reg + 1'b1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            gid_reg  <= group_id;
            va_reg   <= vert_a;
            vb_reg   <= vert_b;
            vc_reg   <= vert_c;
        end

        if (tbl_re)
        begin
            cand_o_reg <= outer_reg;
            cand_i_reg <= inner_eff;
        end

        if (cmd.grp_step && (rd_idx_reg != 3'd0))
        begin
            grp_reg[cap_idx] <= grp_rdata;
        end

        if (cmd.exec)
        begin
            pend_status_reg <= (is_add && !add_v_ok && !add_e_ok && !add_f_ok)
                               ? ST_IGNORED : ST_OK;
            pend_kind_reg   <= '0;
            pend_first_reg  <= '0;
            pend_second_reg <= '0;
        end
        else if (cmd.scan_step && scan_done)
        begin
            pend_status_reg <= ST_FINISHED;
            pend_kind_reg   <= '0;
            pend_first_reg  <= '0;
            pend_second_reg <= '0;
        end
        else if (cmd.set_pair)
        begin
            pend_status_reg <= ST_OK;
            pend_kind_reg   <= phase_reg;
            pend_first_reg  <= INDEX_W'(cand_o_reg);
            pend_second_reg <= INDEX_W'(cand_i_reg);
        end

        if (cmd.emit)
        begin
            out_status_reg <= pend_status_reg;
            out_kind_reg   <= pend_kind_reg;
            out_first_reg  <= pend_first_reg;
            out_second_reg <= pend_second_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_pair_kind    = out_kind_reg;
    assign rsp_first_index  = out_first_reg;
    assign rsp_second_index = out_second_reg;

endmodule

@@ rtl/collision_pair_candidate_generator.sv @@
`timescale 1ns / 1ps
// add, clear and other codes: the beat is latched, executed, then moved to the output register
// next: the beat is latched, the scan state steps the cursors or phase and reads the tables;
//   a candidate is checked for shared vertices and, with group checking on, its vertex groups
//   are read through the one group table read port and compared; then the result is emitted
// one request in flight; a result may wait in the output register while the next is taken
// reset clears counts, scan cursors and output valid; kind mask 7, group check off
// ----------------------------------------------------------------------------
// collision_pair_candidate_generator
// Brute-force broad-phase candidate pair enumerator over loaded edge, face and
// vertex group tables.
// ----------------------------------------------------------------------------
module collision_pair_candidate_generator import cpcg_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 1024,
    parameter int MAX_FACES    = 1024,
    parameter int GROUP_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    cpcg_req_if.sink               req,
    cpcg_rsp_if.source             rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cpcg_cmd_t cmd;
    cpcg_sts_t sts;

    cpcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpcg_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .MAX_FACES    (MAX_FACES),
        .GROUP_BITS   (GROUP_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .func             (req.func),
        .group_id         (req.group_id),
        .vert_a           (req.vert_a),
        .vert_b           (req.vert_b),
        .vert_c           (req.vert_c),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_status       (rsp.status),
        .rsp_pair_kind    (rsp.pair_kind),
        .rsp_first_index  (rsp.first_index),
        .rsp_second_index (rsp.second_index)
    );

endmodule

@@ rtl/cpcg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcg_checker
// Port-level checks on the request/response behavior of the generator.
// ----------------------------------------------------------------------------
module cpcg_checker import cpcg_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [KIND_W-1:0]   rsp_pair_kind,
    input logic [INDEX_W-1:0]  rsp_first_index,
    input logic [INDEX_W-1:0]  rsp_second_index
);

    // one request at a time: busy right after a request beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    // a fresh result means the sequencer is back to taking requests
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result appeared while sequencer still busy");

    // status other than a valid pair carries zero pair fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_pair_kind == '0) && (rsp_first_index == '0)
            && (rsp_second_index == '0))
        else $error("non-pair result with nonzero pair fields");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_pair_kind) && $stable(rsp_first_index)
            && $stable(rsp_second_index))
        else $error("stalled result beat changed");

endmodule

bind collision_pair_candidate_generator cpcg_checker u_cpcg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_pair_kind    (rsp.pair_kind),
    .rsp_first_index  (rsp.first_index),
    .rsp_second_index (rsp.second_index)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the collision pair candidate generator: loads small
// random meshes and walks the pair enumeration under several kind mask and
// group check setting, and compares every result beat against a cycle-free
// model of the scan.
// ----------------------------------------------------------------------------
module tb;
    import cpcg_pkg::*;

    localparam int TBL_DEPTH      = 1024;
    localparam int RANDOM_BEATS   = 600;
    localparam int IDLE_PCT       = 26;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int REPORT_LIMIT   = 20;

    localparam logic [KIND_W-1:0] KIND_EDGE_VERTEX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE_EDGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FACE_VERTEX = 2'd2;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [GROUP_ID_W-1:0] group_id;
        logic [VERT_W-1:0]     vert_a;
        logic [VERT_W-1:0]     vert_b;
        logic [VERT_W-1:0]     vert_c;
    } req_beat_t;

    typedef struct packed {
        status_t              status;
        logic [KIND_W-1:0]    kind;
        logic [INDEX_W-1:0]   first;
        logic [INDEX_W-1:0]   second;
    } pair_result_t;

    // mirror of the mesh tables and scan cursors, plus the queue of pending results
    class pair_tracker;
        typedef enum bit [1:0] {SCAN_EV, SCAN_EE, SCAN_FV, SCAN_DONE} scan_t;

        bit [GROUP_ID_W-1:0] vertex_group [TBL_DEPTH];
        bit [VERT_W-1:0]     edge_end [TBL_DEPTH][2];
        bit [VERT_W-1:0]     face_corner [TBL_DEPTH][3];
        int unsigned         n_vertices;
        int unsigned         n_edges;
        int unsigned         n_faces;
        scan_t               scan_pos;
        int unsigned         outer;
        int unsigned         inner;
        bit [2:0]            kind_mask;
        bit                  group_check;
        pair_result_t        pending_pairs [$];
        int unsigned         errors;

        function new();
            n_vertices  = 0;
            n_edges     = 0;
            n_faces     = 0;
            kind_mask   = 3'd7;
            group_check = 1'b0;
            errors      = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            scan_pos = SCAN_EV;
            outer    = 0;
            inner    = 0;
        endfunction

        function void next_scan_phase();
            scan_pos = scan_pos.next();
            outer    = 0;
            inner    = (scan_pos == SCAN_EE) ? 1 : 0;
        endfunction

        function bit edge_vertex_clear(int unsigned e, int unsigned v);
            bit [VERT_W-1:0]     a;
            bit [VERT_W-1:0]     b;
            bit [GROUP_ID_W-1:0] g;
            a = edge_end[e][0];
            b = edge_end[e][1];
            if (v == a || v == b)
                return 1'b0;
            if (group_check)
            begin
                g = vertex_group[v];
                if (g == vertex_group[a] || g == vertex_group[b])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit edge_edge_clear(int unsigned i, int unsigned j);
            bit [VERT_W-1:0] a;
            bit [VERT_W-1:0] b;
            bit [VERT_W-1:0] c;
            bit [VERT_W-1:0] d;
            a = edge_end[i][0];
            b = edge_end[i][1];
            c = edge_end[j][0];
            d = edge_end[j][1];
            if (a == c || a == d || b == c || b == d)
                return 1'b0;
            if (group_check)
            begin
                if (vertex_group[a] == vertex_group[c] || vertex_group[a] == vertex_group[d] ||
                    vertex_group[b] == vertex_group[c] || vertex_group[b] == vertex_group[d])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit face_vertex_clear(int unsigned f, int unsigned v);
            bit [VERT_W-1:0]     a;
            bit [VERT_W-1:0]     b;
            bit [VERT_W-1:0]     c;
            bit [GROUP_ID_W-1:0] g;
            a = face_corner[f][0];
            b = face_corner[f][1];
            c = face_corner[f][2];
            if (v == a || v == b || v == c)
                return 1'b0;
            if (group_check)
            begin
                g = vertex_group[v];
                if (g == vertex_group[a] || g == vertex_group[b] || g == vertex_group[c])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // steps the cursors to the next surviving pair, 0 once every phase is done
        function bit advance_scan(output bit [KIND_W-1:0] kind, output bit [INDEX_W-1:0] first,
                                  output bit [INDEX_W-1:0] second);
            int unsigned o;
            int unsigned v;
            kind   = '0;
            first  = '0;
            second = '0;
            while (scan_pos != SCAN_DONE)
            begin
                o = outer;
                v = inner;
                case (scan_pos)
                    SCAN_EV:
                    begin
                        if (!kind_mask[0] || o >= n_edges)
                            next_scan_phase();
                        else if (v >= n_vertices)
                        begin
                            outer = o + 1;
                            inner = 0;
                        end
                        else
                        begin
                            inner = v + 1;
                            if (edge_vertex_clear(o, v))
                            begin
                                kind   = KIND_EDGE_VERTEX;
                                first  = INDEX_W'(o);
                                second = INDEX_W'(v);
                                return 1'b1;
                            end
                        end
                    end
                    SCAN_EE:
                    begin
                        if (!kind_mask[1] || o >= n_edges)
                            next_scan_phase();
                        else
                        begin
                            if (v <= o)
                                v = o + 1;
                            if (v >= n_edges)
                            begin
                                outer = o + 1;
                                inner = o + 2;
                            end
                            else
                            begin
                                inner = v + 1;
                                if (edge_edge_clear(o, v))
                                begin
                                    kind   = KIND_EDGE_EDGE;
                                    first  = INDEX_W'(o);
                                    second = INDEX_W'(v);
                                    return 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (!kind_mask[2] || o >= n_faces)
                            next_scan_phase();
                        else if (v >= n_vertices)
                        begin
                            outer = o + 1;
                            inner = 0;
                        end
                        else
                        begin
                            inner = v + 1;
                            if (face_vertex_clear(o, v))
                            begin
                                kind   = KIND_FACE_VERTEX;
                                first  = INDEX_W'(o);
                                second = INDEX_W'(v);
                                return 1'b1;
                            end
                        end
                    end
                endcase
            end
            return 1'b0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_KIND_MASK)
                kind_mask = data[2:0];
            else if (idx == CFG_GROUP_CHECK)
                group_check = data[0];
        endfunction

        function void take_request(req_beat_t r);
            pair_result_t       res;
            bit [KIND_W-1:0]    k;
            bit [INDEX_W-1:0]   f;
            bit [INDEX_W-1:0]   s;
            res.status = ST_OK;
            res.kind   = '0;
            res.first  = '0;
            res.second = '0;
            case (r.func)
                FUNC_CLEAR:
                begin
                    n_vertices = 0;
                    n_edges    = 0;
                    n_faces    = 0;
                    restart_scan();
                end
                FUNC_ADD_VERTEX:
                begin
                    if (n_vertices >= TBL_DEPTH)
                        res.status = ST_IGNORED;
                    else
                    begin
                        vertex_group[n_vertices] = r.group_id;
                        n_vertices++;
                    end
                    restart_scan();
                end
                FUNC_ADD_EDGE:
                begin
                    if (n_edges >= TBL_DEPTH || r.vert_a >= n_vertices || r.vert_b >= n_vertices)
                        res.status = ST_IGNORED;
                    else
                    begin
                        edge_end[n_edges][0] = r.vert_a;
                        edge_end[n_edges][1] = r.vert_b;
                        n_edges++;
                    end
                    restart_scan();
                end
                FUNC_ADD_FACE:
                begin
                    if (n_faces >= TBL_DEPTH || r.vert_a >= n_vertices ||
                        r.vert_b >= n_vertices || r.vert_c >= n_vertices)
                        res.status = ST_IGNORED;
                    else
                    begin
                        face_corner[n_faces][0] = r.vert_a;
                        face_corner[n_faces][1] = r.vert_b;
                        face_corner[n_faces][2] = r.vert_c;
                        n_faces++;
                    end
                    restart_scan();
                end
                FUNC_NEXT:
                begin
                    if (advance_scan(k, f, s))
                    begin
                        res.kind   = k;
                        res.first  = f;
                        res.second = s;
                    end
                    else
                        res.status = ST_FINISHED;
                end
                default: ;
            endcase
            pending_pairs.push_back(res);
        endfunction

        function void check_response(pair_result_t got);
            pair_result_t want;
            if (pending_pairs.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat status %0d kind %0d first %0d second %0d",
                             $time, got.status, got.kind, got.first, got.second);
                return;
            end
            want = pending_pairs.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, want.status, want.kind, want.first, want.second,
                             got.status, got.kind, got.first, got.second);
            end
        endfunction

        function int unsigned pending();
            return pending_pairs.size();
        endfunction

        function bit scan_finished();
            return scan_pos == SCAN_DONE;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cpcg_req_if req_ch ();
    cpcg_rsp_if rsp_ch ();

    pair_tracker tracker = new();

    int unsigned req_idle_pct = IDLE_PCT;
    int unsigned rsp_idle_pct = IDLE_PCT;
    bit          hold_request = 1'b0;
    int unsigned beats_sent   = 0;

    collision_pair_candidate_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic req_beat_t random_beat(input logic [FUNC_W-1:0] f);
        req_beat_t b;
        b.func     = f;
        b.group_id = GROUP_ID_W'($urandom);
        b.vert_a   = VERT_W'($urandom);
        b.vert_b   = VERT_W'($urandom);
        b.vert_c   = VERT_W'($urandom);
        return b;
    endfunction

    // mostly a loaded vertex, now and then one at or past the end of the loaded range
    function automatic logic [VERT_W-1:0] pick_corner(input int unsigned nv);
        if ($urandom_range(0, 11) == 0)
            return VERT_W'($urandom_range(nv, TBL_DEPTH - 1));
        return VERT_W'($urandom_range(0, nv - 1));
    endfunction

    task automatic send_beat(input req_beat_t beat);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= beat.func;
        req_ch.group_id <= beat.group_id;
        req_ch.vert_a   <= beat.vert_a;
        req_ch.vert_b   <= beat.vert_b;
        req_ch.vert_c   <= beat.vert_c;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        tracker.take_request(beat);
        beats_sent++;
    endtask

    task automatic send_func(input logic [FUNC_W-1:0] f);
        send_beat(random_beat(f));
    endtask

    task automatic add_vertex(input logic [GROUP_ID_W-1:0] g);
        req_beat_t b;
        b = random_beat(FUNC_ADD_VERTEX);
        b.group_id = g;
        send_beat(b);
    endtask

    task automatic add_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] bv);
        req_beat_t b;
        b = random_beat(FUNC_ADD_EDGE);
        b.vert_a = a;
        b.vert_b = bv;
        send_beat(b);
    endtask

    task automatic add_face(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] bv,
                            input logic [VERT_W-1:0] c);
        req_beat_t b;
        b = random_beat(FUNC_ADD_FACE);
        b.vert_a = a;
        b.vert_b = bv;
        b.vert_c = c;
        send_beat(b);
    endtask

    // drop valid, drain every pending result, then let the block go quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write enable stays high across both register writes
    task automatic apply_setting(input logic [2:0] mask, input logic gc);
        logic [CFG_DATA_W-1:0] gc_word;
        gc_word = CFG_DATA_W'($urandom);
        gc_word[0] = gc;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KIND_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        tracker.write_register(CFG_KIND_MASK, mask);
        cfg_index <= CFG_GROUP_CHECK;
        cfg_data  <= gc_word;
        @(posedge clk);
        tracker.write_register(CFG_GROUP_CHECK, gc_word);
        cfg_we <= 1'b0;
    endtask

    task automatic build_scene();
        logic [GROUP_ID_W-1:0] pool [3];
        int unsigned           nv;
        int unsigned           ne;
        int unsigned           nf;
        int unsigned           i;
        for (i = 0; i < 3; i++)
            pool[i] = GROUP_ID_W'($urandom);
        nv = $urandom_range(2, 10);
        ne = $urandom_range(0, 8);
        nf = $urandom_range(0, 4);
        send_func(FUNC_CLEAR);
        // an edge before any vertex is loaded
        if ($urandom_range(0, 3) == 0)
            add_edge(pick_corner(nv), pick_corner(nv));
        for (i = 0; i < nv; i++)
            add_vertex(($urandom_range(0, 4) == 0) ? GROUP_ID_W'($urandom)
                                                   : pool[$urandom_range(0, 2)]);
        for (i = 0; i < ne; i++)
            add_edge(pick_corner(nv), pick_corner(nv));
        for (i = 0; i < nf; i++)
            add_face(pick_corner(nv), pick_corner(nv), pick_corner(nv));
    endtask

    task automatic walk_pairs();
        int unsigned guard;
        guard = 0;
        while (!tracker.scan_finished() && guard < 250)
        begin
            if ($urandom_range(0, 19) == 0)
                send_func(FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1)));
            else
                send_func(FUNC_NEXT);
            guard++;
        end
        repeat ($urandom_range(1, 2)) send_func(FUNC_NEXT);
    endtask

    // result side: checks accepted beats and drives ready, with one long hold-off
    initial
    begin
        int unsigned  hold_left;
        pair_result_t got;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status = status_t'(rsp_ch.status);
                got.kind   = rsp_ch.pair_kind;
                got.first  = rsp_ch.first_index;
                got.second = rsp_ch.second_index;
                tracker.check_response(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned random_goal;
        int unsigned phase_no;
        logic [2:0]  mask;
        logic        gc;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.func     = '0;
        req_ch.group_id = '0;
        req_ch.vert_a   = '0;
        req_ch.vert_b   = '0;
        req_ch.vert_c   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty scan, reserved codes, unloaded endpoints, group extremes
        send_func(FUNC_NEXT);
        send_func(FUNC_RESERVED_5);
        send_func(FUNC_RESERVED_7);
        add_edge(10'd1023, 10'd0);
        add_vertex(16'h0000);
        add_vertex(16'hFFFF);
        add_vertex(16'h0000);
        add_vertex(16'hABCD);
        add_vertex(16'hFFFF);
        add_edge(10'd0, 10'd1);
        add_edge(10'd2, 10'd4);
        add_edge(10'd1, 10'd3);
        add_edge(10'd0, 10'd5);
        add_face(10'd0, 10'd1, 10'd2);
        add_face(10'd3, 10'd4, 10'd1023);
        repeat (4) send_func(FUNC_NEXT);
        // register writes mid-scan take effect without a restart
        settle();
        apply_setting(3'd7, 1'b1);
        repeat (4) send_func(FUNC_NEXT);
        settle();
        apply_setting(3'd0, 1'b1);
        send_func(FUNC_NEXT);
        settle();

        random_goal = beats_sent + RANDOM_BEATS;
        phase_no    = 0;
        while (beats_sent < random_goal)
        begin
            case (phase_no)
                0:       begin mask = 3'd7; gc = 1'b1; end
                1:       begin mask = 3'd1; gc = 1'b0; end
                2:       begin mask = 3'd2; gc = 1'b1; end
                3:       begin mask = 3'd4; gc = 1'b0; end
                4:       begin mask = 3'd0; gc = 1'b1; end
                5:       begin mask = 3'd7; gc = 1'b0; end
                default: begin mask = 3'($urandom_range(0, 7)); gc = 1'($urandom_range(0, 1)); end
            endcase
            apply_setting(mask, gc);
            req_idle_pct = (phase_no == 5) ? 0 : IDLE_PCT;
            rsp_idle_pct = (phase_no == 5) ? 0 : IDLE_PCT;
            build_scene();
            // result side stalls while requests keep coming
            if (phase_no == 1)
                hold_request = 1'b1;
            walk_pairs();
            settle();
            phase_no++;
        end

        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
